// ===== rtl/gha_pkg.sv =====
package gha_pkg;

  // Slot space and handle field widths
  localparam int MAX_SLOTS = 1024;
  localparam int IDX_W     = $clog2(MAX_SLOTS);
  localparam int GEN_W     = 16;
  localparam int COUNT_W   = IDX_W + 1;
  localparam int SLOT_W    = GEN_W + 1;   // {alive, generation}
  localparam int TDATA_W   = ((IDX_W + GEN_W + 7) / 8) * 8;
  localparam int PAD_W     = TDATA_W - IDX_W - GEN_W;

  // Request kinds
  localparam logic [1:0] ACT_CREATE  = 2'd0;
  localparam logic [1:0] ACT_DESTROY = 2'd1;
  localparam logic [1:0] ACT_QUERY   = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_DEAD = 2'd2;

  // Controller to datapath
  typedef struct packed {
    logic accept;     // latch request, issue slot and stack reads
    logic pop_read;   // read slot memory at the popped index
    logic commit;     // update state and load the result register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic pop_needed; // incoming request is a create served from the free stack
    logic out_busy;   // result register full and not taken this cycle
  } stat_t;

endpackage

// ===== rtl/generational_handle_allocator_unit.sv =====
// Channel   Direction  Handshake            Contents
// s_*       in         s_tvalid / s_tready  request: action, handle index and generation
// m_*       out        m_tvalid / m_tready  result: status, handle index and generation
//
// Destroy, query and a create that takes a fresh slot go from the capture step
// straight to commit; a create that reuses a freed slot passes a pop step
// between them, since the free stack read must return before the slot memory
// can be read at it. The registered read port of the slot memory sets these steps.
// Reset clears the counters, out_valid and the controller; memories need no clearing.
// A finished result waits in the output register while the next request is
// taken; the block holds in its commit step only while that register is full.
module generational_handle_allocator_unit (
  input  logic                         clk,
  input  logic                         rst,
  // request
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [gha_pkg::TDATA_W-1:0]  s_tdata,   // entity_index, entity_generation, zero pad
  input  logic [1:0]                   s_tuser,   // action
  // result
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [gha_pkg::TDATA_W-1:0]  m_tdata,   // out_index, out_generation, zero pad
  output logic [1:0]                   m_tuser    // status
);
  import gha_pkg::*;

  cmd_t              cmd;
  stat_t             st;
  logic [IDX_W-1:0]  res_index;
  logic [GEN_W-1:0]  res_gen;

  // Sequence each request: capture, optional pop, commit
  gha_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  // Slot memory, free stack, counters and result register
  gha_datapath u_datapath (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .st                (st),
    .action            (s_tuser),
    .entity_index      (s_tdata[IDX_W-1:0]),
    .entity_generation (s_tdata[IDX_W+GEN_W-1:IDX_W]),
    .out_valid         (m_tvalid),
    .out_ready         (m_tready),
    .status            (m_tuser),
    .out_index         (res_index),
    .out_generation    (res_gen)
  );

  assign m_tdata = {PAD_W'(0), res_gen, res_index};

endmodule

// ===== rtl/gha_ctrl.sv =====
module gha_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  gha_pkg::stat_t st,
  output gha_pkg::cmd_t  cmd
);
  import gha_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_EXEC
  } state_t;

  state_t state;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.accept   = (state == S_IDLE) && s_tvalid;
    cmd.pop_read = (state == S_POP);
    cmd.commit   = (state == S_EXEC) && !st.out_busy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            state <= st.pop_needed ? S_POP : S_EXEC;
          end
        end
        S_POP: begin
          state <= S_EXEC;
        end
        S_EXEC: begin
          // hold until the result register can take the answer
          if (!st.out_busy) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/gha_datapath.sv =====
module gha_datapath (
  input  logic                      clk,
  input  logic                      rst,
  input  gha_pkg::cmd_t             cmd,
  output gha_pkg::stat_t            st,
  input  logic [1:0]                action,
  input  logic [gha_pkg::IDX_W-1:0] entity_index,
  input  logic [gha_pkg::GEN_W-1:0] entity_generation,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [1:0]                status,
  output logic [gha_pkg::IDX_W-1:0] out_index,
  output logic [gha_pkg::GEN_W-1:0] out_generation
);
  import gha_pkg::*;

  localparam logic [COUNT_W-1:0] CNT_ONE = COUNT_W'(1);
  localparam logic [COUNT_W-1:0] CNT_MAX = COUNT_W'(MAX_SLOTS);
  localparam logic [GEN_W-1:0]   GEN_ONE = GEN_W'(1);

  // Slot memory holds {alive, generation}; the free stack holds slot indexes
  logic [SLOT_W-1:0] slot_mem  [MAX_SLOTS];
  logic [IDX_W-1:0]  stack_mem [MAX_SLOTS];

  logic [1:0]         req_action;
  logic [IDX_W-1:0]   req_index;
  logic [GEN_W-1:0]   req_gen;
  logic [SLOT_W-1:0]  slot_rd;
  logic [IDX_W-1:0]   stack_rd;
  logic [COUNT_W-1:0] free_count;
  logic [COUNT_W-1:0] slots_used;

  logic [COUNT_W-1:0] free_count_next;
  logic [COUNT_W-1:0] slots_used_next;
  logic               slot_we;
  logic [IDX_W-1:0]   slot_waddr;
  logic [SLOT_W-1:0]  slot_wdata;
  logic               stack_we;
  logic [IDX_W-1:0]   slot_raddr;
  logic [IDX_W-1:0]   stack_raddr;
  logic               handle_alive;
  logic [1:0]         res_status;
  logic [IDX_W-1:0]   res_index;
  logic [GEN_W-1:0]   res_gen;

  assign st.pop_needed = (action == ACT_CREATE) && (free_count != '0);
  assign st.out_busy   = out_valid && !out_ready;

  assign slot_raddr  = cmd.pop_read ? stack_rd : entity_index;
  assign stack_raddr = free_count[IDX_W-1:0] - IDX_W'(1);

  assign handle_alive = ({1'b0, req_index} < slots_used) && slot_rd[GEN_W]
                        && (slot_rd[GEN_W-1:0] == req_gen);

  always_comb begin
    free_count_next = free_count;
    slots_used_next = slots_used;
    slot_we         = 1'b0;
    slot_waddr      = req_index;
    slot_wdata      = slot_rd;
    stack_we        = 1'b0;
    res_status      = ST_OK;
    res_index       = req_index;
    res_gen         = req_gen;
    case (req_action)
      ACT_CREATE: begin
        if (free_count != '0) begin
          // reuse the most recently freed slot, keep its generation
          free_count_next = free_count - CNT_ONE;
          slot_we         = 1'b1;
          slot_waddr      = stack_rd;
          slot_wdata      = {1'b1, slot_rd[GEN_W-1:0]};
          res_index       = stack_rd;
          res_gen         = slot_rd[GEN_W-1:0];
        end else if (slots_used < CNT_MAX) begin
          // first use of a fresh slot
          slots_used_next = slots_used + CNT_ONE;
          slot_we         = 1'b1;
          slot_waddr      = slots_used[IDX_W-1:0];
          slot_wdata      = {1'b1, GEN_ONE};
          res_index       = slots_used[IDX_W-1:0];
          res_gen         = GEN_ONE;
        end else begin
          res_status = ST_FULL;
          res_index  = '0;
          res_gen    = '0;
        end
      end
      ACT_DESTROY: begin
        if (handle_alive && (free_count < CNT_MAX)) begin
          free_count_next = free_count + CNT_ONE;
          slot_we         = 1'b1;
          slot_wdata      = {1'b0, slot_rd[GEN_W-1:0] + GEN_ONE};
          stack_we        = 1'b1;
        end else begin
          res_status = ST_DEAD;
        end
      end
      default: begin
        if (!handle_alive) begin
          res_status = ST_DEAD;
        end
      end
    endcase
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_action <= action;
      req_index  <= entity_index;
      req_gen    <= entity_generation;
    end
  end

  // Slot memory: one read port, one write port
  always_ff @(posedge clk) begin
    if (cmd.accept || cmd.pop_read) begin
      slot_rd <= slot_mem[slot_raddr];
    end
    if (cmd.commit && slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
  end

  // Free stack: read the top on accept, push on destroy
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      stack_rd <= stack_mem[stack_raddr];
    end
    if (cmd.commit && stack_we) begin
      stack_mem[free_count[IDX_W-1:0]] <= req_index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_count <= '0;
      slots_used <= '0;
    end else if (cmd.commit) begin
      free_count <= free_count_next;
      slots_used <= slots_used_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status         <= res_status;
      out_index      <= res_index;
      out_generation <= res_gen;
    end
  end

endmodule

// ===== tb/sv/handle_table_checker.sv =====
module handle_table_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  input  logic                        s_tready,
  input  logic [gha_pkg::TDATA_W-1:0] s_tdata,   // entity_index, entity_generation, zero pad
  input  logic [1:0]                  s_tuser,   // action
  input  logic                        m_tvalid,
  input  logic                        m_tready,
  input  logic [gha_pkg::TDATA_W-1:0] m_tdata,   // out_index, out_generation, zero pad
  input  logic [1:0]                  m_tuser,   // status
  output int                          mismatch_count,
  output int                          results_pending
);
  import gha_pkg::*;

  typedef struct packed {
    logic [1:0]       status;
    logic [IDX_W-1:0] slot;
    logic [GEN_W-1:0] gen;
  } handle_result_t;

  // Own copy of the allocator state
  logic [GEN_W-1:0] slot_gen   [MAX_SLOTS];
  logic             slot_alive [MAX_SLOTS];
  logic [IDX_W-1:0] free_slots [MAX_SLOTS];
  int unsigned      free_depth;
  int unsigned      fresh_next;

  handle_result_t   results_due[$];

  function automatic bit handle_live(logic [IDX_W-1:0] idx, logic [GEN_W-1:0] gen);
    return (idx < fresh_next) && slot_alive[idx] && (slot_gen[idx] == gen);
  endfunction

  // Apply one request to the state and return the result it must produce
  function automatic handle_result_t apply_handle_request(logic [1:0] act,
                                                          logic [IDX_W-1:0] idx,
                                                          logic [GEN_W-1:0] gen);
    handle_result_t r;
    logic [IDX_W-1:0] slot;
    r = '{status: ST_OK, slot: idx, gen: gen};
    case (act)
      ACT_CREATE: begin
        if (free_depth > 0) begin
          free_depth--;
          slot = free_slots[free_depth];
          slot_alive[slot] = 1'b1;
          r = '{status: ST_OK, slot: slot, gen: slot_gen[slot]};
        end else if (fresh_next < MAX_SLOTS) begin
          slot = fresh_next[IDX_W-1:0];
          fresh_next++;
          slot_gen[slot] = GEN_W'(1);
          slot_alive[slot] = 1'b1;
          r = '{status: ST_OK, slot: slot, gen: slot_gen[slot]};
        end else begin
          r = '{status: ST_FULL, slot: '0, gen: '0};
        end
      end
      ACT_DESTROY: begin
        if (handle_live(idx, gen) && free_depth < MAX_SLOTS) begin
          slot_alive[idx] = 1'b0;
          slot_gen[idx] = slot_gen[idx] + 1'b1;
          free_slots[free_depth] = idx;
          free_depth++;
        end else begin
          r.status = ST_DEAD;
        end
      end
      default: begin
        // query, and the spare action code behaves as one
        if (!handle_live(idx, gen)) r.status = ST_DEAD;
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    handle_result_t want;
    if (rst) begin
      for (int k = 0; k < MAX_SLOTS; k++) slot_alive[k] = 1'b0;
      free_depth = 0;
      fresh_next = 0;
      mismatch_count = 0;
      results_due.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (results_due.size() == 0) begin
          $error("result with nothing outstanding: status %0d index %0d generation %0d",
                 m_tuser, m_tdata[IDX_W-1:0], m_tdata[IDX_W +: GEN_W]);
          mismatch_count++;
        end else begin
          want = results_due.pop_front();
          if (m_tuser !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, m_tuser);
            mismatch_count++;
          end
          if (m_tdata[IDX_W-1:0] !== want.slot) begin
            $error("out_index: expected %0d, actual %0d", want.slot, m_tdata[IDX_W-1:0]);
            mismatch_count++;
          end
          if (m_tdata[IDX_W +: GEN_W] !== want.gen) begin
            $error("out_generation: expected %0d, actual %0d", want.gen,
                   m_tdata[IDX_W +: GEN_W]);
            mismatch_count++;
          end
          if (m_tdata[TDATA_W-1 -: PAD_W] !== '0) begin
            $error("m_tdata pad: expected 0, actual %0h", m_tdata[TDATA_W-1 -: PAD_W]);
            mismatch_count++;
          end
        end
      end
      if (s_tvalid && s_tready)
        results_due.push_back(apply_handle_request(s_tuser, s_tdata[IDX_W-1:0],
                                                   s_tdata[IDX_W +: GEN_W]));
    end
    results_pending = results_due.size();
  end

endmodule

// ===== tb/sv/generational_handle_allocator_unit_tb.sv =====
module generational_handle_allocator_unit_tb;
  import gha_pkg::*;

  localparam int          HANDLE_W    = IDX_W + GEN_W;
  localparam int          STALE_KEEP  = 64;
  // Upper bound on the run length; a hung block stops the run here
  localparam longint      CYCLE_LIMIT = 200000;
  // The fourth action code has no meaning of its own
  localparam logic [1:0]  ACT_SPARE   = 2'd3;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [TDATA_W-1:0] s_tdata = '0;   // entity_index, entity_generation, zero pad
  logic [1:0]         s_tuser = '0;   // action
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [TDATA_W-1:0] m_tdata;        // out_index, out_generation, zero pad
  logic [1:0]         m_tuser;        // status

  int     mismatch_count;
  int     results_pending;
  int     send_idle = 27;
  int     recv_idle = 64;
  longint cycle_count = 0;

  // Stimulus bookkeeping: handles learnt from create results, handles already
  // released, and the action of every request still awaiting its result
  logic [HANDLE_W-1:0] live_pool[$];
  logic [HANDLE_W-1:0] stale_pool[$];
  logic [1:0]          sent_actions[$];
  bit                  track_creates = 1'b0;
  int                  sent_by_action[4];
  int                  seen_ok, seen_full, seen_dead;

  always #2 clk = ~clk;

  generational_handle_allocator_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  handle_table_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .s_tuser         (s_tuser),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .m_tuser         (m_tuser),
    .mismatch_count  (mismatch_count),
    .results_pending (results_pending)
  );

  // Stall the result side at random, one decision per cycle
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle);
  end

  // Harvest handles from create results so that later requests can use them
  always @(posedge clk) begin
    logic [1:0] act;
    if (!rst && m_tvalid && m_tready && sent_actions.size() > 0) begin
      act = sent_actions.pop_front();
      if (m_tuser == ST_OK) seen_ok++;
      else if (m_tuser == ST_FULL) seen_full++;
      else seen_dead++;
      if (act == ACT_CREATE && m_tuser == ST_OK && track_creates)
        live_pool.push_back(m_tdata[HANDLE_W-1:0]);
    end
  end

  // Give up on a hung block
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Present one request from a falling edge, hold it until taken, and return
  // at the next falling edge with valid still high
  task automatic send_request(input logic [1:0] act, input logic [IDX_W-1:0] idx,
                              input logic [GEN_W-1:0] gen);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {{PAD_W{1'b0}}, gen, idx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent_actions.push_back(act);
    sent_by_action[act]++;
    @(negedge clk);
  endtask

  // Hold the request side until every outstanding result has come back
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (results_pending != 0) @(negedge clk);
  endtask

  function automatic logic [HANDLE_W-1:0] pick_from(ref logic [HANDLE_W-1:0] pool[$]);
    return pool[$urandom_range(pool.size() - 1)];
  endfunction

  // One random request: mostly well-formed handles, weighted per phase,
  // the remainder noise (random action, stale handles, near-miss generations)
  task automatic issue_random(input int create_pct, input int destroy_pct,
                              input int query_pct);
    int                  pick;
    int                  k;
    logic [1:0]          act;
    logic [IDX_W-1:0]    idx;
    logic [GEN_W-1:0]    gen;
    logic [HANDLE_W-1:0] h;
    pick = $urandom_range(99);
    act  = ACT_CREATE;
    idx  = IDX_W'($urandom_range(MAX_SLOTS - 1));
    gen  = GEN_W'($urandom_range(16'hFFFF));
    if (pick < create_pct) begin
      act = ACT_CREATE;
    end else if (pick < create_pct + destroy_pct) begin
      // release a known live handle; fall back to a create when none is known
      if (live_pool.size() > 0) begin
        k = $urandom_range(live_pool.size() - 1);
        h = live_pool[k];
        live_pool.delete(k);
        stale_pool.push_back(h);
        if (stale_pool.size() > STALE_KEEP) void'(stale_pool.pop_front());
        act = ACT_DESTROY;
        {gen, idx} = h;
      end
    end else if (pick < create_pct + destroy_pct + query_pct) begin
      act = ACT_QUERY;
      if (live_pool.size() > 0 && $urandom_range(3) != 0) {gen, idx} = pick_from(live_pool);
      else if (stale_pool.size() > 0) {gen, idx} = pick_from(stale_pool);
    end else begin
      act = 2'($urandom_range(3));
      case ($urandom_range(2))
        0: if (stale_pool.size() > 0) {gen, idx} = pick_from(stale_pool);
        1: begin
          if (live_pool.size() > 0) begin
            {gen, idx} = pick_from(live_pool);
            gen[$urandom_range(GEN_W - 1)] ^= 1'b1;
          end
        end
        default: ;
      endcase
    end
    send_request(act, idx, gen);
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: out-of-range and empty-table handles, first allocations,
    // liveness with right and wrong generations, the spare action code,
    // double release, and reuse of the latest freed slot ahead of fresh ones
    send_request(ACT_QUERY,   '0, '0);
    send_request(ACT_DESTROY, '1, '1);
    send_request(ACT_CREATE,  '1, '1);
    send_request(ACT_CREATE,  '0, '0);
    send_request(ACT_QUERY,   10'd0, 16'd1);
    send_request(ACT_QUERY,   10'd0, 16'd2);
    send_request(ACT_SPARE,   10'd0, 16'd1);
    send_request(ACT_SPARE,   '1, '1);
    send_request(ACT_DESTROY, 10'd1, 16'd0);
    send_request(ACT_DESTROY, 10'd0, 16'd1);
    send_request(ACT_DESTROY, 10'd0, 16'd1);
    send_request(ACT_QUERY,   10'd0, 16'd1);
    send_request(ACT_DESTROY, 10'd1, 16'd1);
    send_request(ACT_CREATE,  '0, '0);
    send_request(ACT_CREATE,  '0, '0);
    send_request(ACT_CREATE,  '0, '0);
    send_request(ACT_QUERY,   10'd1, 16'd2);
    send_request(ACT_QUERY,   10'd2, 16'hFFFF);
    send_request(ACT_QUERY,   '1, '0);
    send_request(ACT_DESTROY, 10'd2, 16'd1);
    send_request(ACT_QUERY,   10'd2, 16'd1);

    // Let the block run dry before switching on handle harvesting
    drain_results();
    track_creates = 1'b1;

    // Phase one: mixed traffic while the table grows
    for (int n = 0; n < 450; n++) issue_random(60, 15, 15);

    // Phase two: heavy allocation until the table is full, idling swapped
    send_idle = 64;
    recv_idle = 27;
    for (int n = 0; n < 1000; n++) issue_random(95, 2, 2);

    // Phase three: release-heavy traffic, no idling on either side
    send_idle = 0;
    recv_idle = 0;
    for (int n = 0; n < 400; n++) issue_random(15, 55, 20);

    // Wait for the tail, then keep watching for any stray result
    drain_results();
    repeat (8) @(negedge clk);

    $display("Requests: %0d create, %0d destroy, %0d query, %0d spare-code",
             sent_by_action[ACT_CREATE], sent_by_action[ACT_DESTROY],
             sent_by_action[ACT_QUERY], sent_by_action[ACT_SPARE]);
    $display("Results: %0d ok, %0d table full, %0d handle not alive",
             seen_ok, seen_full, seen_dead);
    if (mismatch_count == 0 && results_pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
